// ===== rtl/core/nmnf_pkg.sv =====
// nmnf_pkg: shared types and constants of the neighbour mean noise filter.
// No dependencies; used by every other file of the block.
`default_nettype none
package nmnf_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = 12;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 2;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [SUM_W-1:0] sum_t;

	localparam pixel_t PIX_BLACK = 8'd0;
	localparam pixel_t PIX_WHITE = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_THR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_THR = 2'd3;

	// which neighbour directions of the center lie inside the frame
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} nmnf_edge_t;

endpackage
`default_nettype wire

// ===== rtl/core/nmnf_if.sv =====
// nmnf_if: valid/ready stream interfaces for request and result beats.
// Depends on nmnf_pkg.
`default_nettype none
interface nmnf_req_if import nmnf_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	pixel_t pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface nmnf_rsp_if import nmnf_pkg::*; ();
	logic valid;
	logic ready;
	pixel_t pixel_out;
	logic frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nmnf_delay.sv =====
// nmnf_delay: programmable pixel delay line in a synchronous RAM, advanced per step.
// Read data is prefetched one step ahead; a delay of one uses the previous input.
// Depends on nmnf_pkg.
`default_nettype none
module nmnf_delay import nmnf_pkg::*; #(
	parameter int ADDR_W = 8,
	parameter int DLY_W = 9
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [DLY_W-1:0] delay,
	input wire pixel_t din,
	output pixel_t dout
);

	pixel_t mem [2**ADDR_W];
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] rd_addr;
	pixel_t rd_q;
	pixel_t last_q;

	assign rd_addr = wp_q + ADDR_W'(1) - delay[ADDR_W-1:0];
	assign dout = (delay == DLY_W'(1)) ? last_q : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (step) begin
			wp_q <= wp_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mem[wp_q] <= din;
			rd_q <= mem[rd_addr];
			last_q <= din;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/nmnf_window.sv =====
// nmnf_window: 3x3 neighbourhood registers, masked neighbour sum and the
// salt/pepper decision for the center pixel. Depends on nmnf_pkg.
`default_nettype none
module nmnf_window import nmnf_pkg::*; (
	input wire logic clk,
	input wire logic step,
	input wire pixel_t pixel_in,
	input wire pixel_t raw_dly,
	input wire pixel_t cor_dly,
	input wire nmnf_edge_t edges,
	input wire pixel_t white_thr,
	input wire pixel_t black_thr,
	output pixel_t center_out
);

	// rows: t = above, m = center row, b = below; columns 1..2 left to right,
	// the right column comes straight from the inputs
	pixel_t t1_q, t2_q, m1_q, m2_q, b1_q, b2_q;
	sum_t sum;
	sum_t wt, w_bound, b_bound;
	pixel_t center;
	logic rows3, cols3;

	function automatic sum_t term(input pixel_t v, input logic ok);
		return ok ? {{(SUM_W-PIX_W){1'b0}}, v} : '0;
	endfunction

	always_comb begin
		sum = term(t1_q, edges.top && edges.left) + term(t2_q, edges.top)
			+ term(cor_dly, edges.top && edges.right) + term(m1_q, edges.left)
			+ term(raw_dly, edges.right) + term(b1_q, edges.bottom && edges.left)
			+ term(b2_q, edges.bottom) + term(pixel_in, edges.bottom && edges.right);
		rows3 = edges.top && edges.bottom;
		cols3 = edges.left && edges.right;
		// mean > white  <=>  sum >= (white + 1) * n ; mean < black <=> sum < black * n
		wt = {{(SUM_W-PIX_W){1'b0}}, white_thr} + SUM_W'(1);
		if (rows3 && cols3) begin
			w_bound = wt << 3;
			b_bound = {{(SUM_W-PIX_W){1'b0}}, black_thr} << 3;
		end else if (rows3 || cols3) begin
			w_bound = (wt << 2) + wt;
			b_bound = ({{(SUM_W-PIX_W){1'b0}}, black_thr} << 2)
				+ {{(SUM_W-PIX_W){1'b0}}, black_thr};
		end else begin
			w_bound = (wt << 1) + wt;
			b_bound = ({{(SUM_W-PIX_W){1'b0}}, black_thr} << 1)
				+ {{(SUM_W-PIX_W){1'b0}}, black_thr};
		end
		center = m2_q;
		if (m2_q == PIX_BLACK) begin
			if (sum >= w_bound) center = PIX_WHITE;
		end else if (m2_q == PIX_WHITE) begin
			if (sum < b_bound) center = PIX_BLACK;
		end
	end

	assign center_out = center;

	always_ff @(posedge clk) begin
		if (step) begin
			t1_q <= t2_q;
			t2_q <= cor_dly;
			m1_q <= center;
			m2_q <= raw_dly;
			b1_q <= b2_q;
			b2_q <= pixel_in;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/neighbour_mean_noise_filter_core.sv =====
// neighbour_mean_noise_filter_core: 3x3 salt-and-pepper filter on a raster stream.
// Channel req (sink): req_type 0 carries the next pixel of the frame, req_type 1
//   drains one pending output once the whole frame has arrived.
// Channel rsp (source): corrected pixels in raster order; frame_end marks the last.
// Config: cfg_we/cfg_index/cfg_data write width, height, white and black
//   thresholds; writing width or height restarts the frame.
// Pixel p is produced by the beat carrying pixel p+W+1, or by a drain beat at the
//   end of the frame; the result appears on rsp in the cycle after that beat.
// Throughput: one beat per cycle unless rsp stalls. The neighbour sum and decision
//   for a pixel are combinational, fed by two line delays in RAM (raw pixels delayed W
//   steps, corrected pixels delayed W-1 steps) whose read data is fetched a step ahead.
// Reset: counters cleared, config registers at their defaults; line memories need no clearing.
// Stall: the result is held in an output register; while it waits and rsp.ready
//   is low, req.ready is low.
`default_nettype none
module neighbour_mean_noise_filter_core import nmnf_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	nmnf_req_if.sink req,
	nmnf_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	pixel_t white_q, black_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [HW-1:0] in_row_q, out_row_q;
	logic out_valid_q;
	pixel_t pixel_out_q;
	logic frame_end_q;

	logic in_fire, is_pix, complete, started, step, emit, last;
	logic [8:0] cw_val;
	logic [12:0] ch_val;
	nmnf_edge_t edges;
	pixel_t raw_dly, cor_dly, center;

	assign req.ready = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.pixel_out = pixel_out_q;
	assign rsp.frame_end = frame_end_q;

	assign in_fire = req.valid && req.ready;
	assign is_pix = !req.req_type;
	assign complete = (in_row_q == h_q);
	assign started = (in_row_q > HW'(1)) || ((in_row_q == HW'(1)) && (in_col_q != '0));
	assign step = in_fire && (is_pix != complete);
	assign emit = in_fire && ((is_pix && !complete && started) || (!is_pix && complete));
	assign last = (out_row_q == h_q - HW'(1)) && (WW'(out_col_q) == w_q - WW'(1));
	assign cw_val = cfg_data[8:0];
	assign ch_val = cfg_data[12:0];

	assign edges.top = (out_row_q != '0);
	assign edges.bottom = (out_row_q != h_q - HW'(1));
	assign edges.left = (out_col_q != '0);
	assign edges.right = (WW'(out_col_q) != w_q - WW'(1));

	nmnf_delay #(.ADDR_W(AW), .DLY_W(WW)) u_raw_dly (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.delay(w_q),
		.din(req.pixel_in),
		.dout(raw_dly)
	);

	nmnf_delay #(.ADDR_W(AW), .DLY_W(WW)) u_cor_dly (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.delay(w_q - WW'(1)),
		.din(center),
		.dout(cor_dly)
	);

	nmnf_window u_window (
		.clk(clk),
		.step(step),
		.pixel_in(req.pixel_in),
		.raw_dly(raw_dly),
		.cor_dly(cor_dly),
		.edges(edges),
		.white_thr(white_q),
		.black_thr(black_q),
		.center_out(center)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
			white_q <= 8'd150;
			black_q <= 8'd96;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step && is_pix) begin
				if (WW'(in_col_q) == w_q - WW'(1)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (emit) begin
				if (last) begin
					in_col_q <= '0;
					in_row_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (WW'(out_col_q) == w_q - WW'(1)) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						if (cw_val < 9'd2) w_q <= WW'(2);
						else if (32'(cw_val) > MAX_WIDTH) w_q <= WW'(MAX_WIDTH);
						else w_q <= WW'(cw_val);
						in_col_q <= '0;
						in_row_q <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						if (ch_val < 13'd2) h_q <= HW'(2);
						else if (32'(ch_val) > MAX_HEIGHT) h_q <= HW'(MAX_HEIGHT);
						else h_q <= HW'(ch_val);
						in_col_q <= '0;
						in_row_q <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
					REG_WHITE_THR: white_q <= cfg_data[7:0];
					REG_BLACK_THR: black_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_out_q <= center;
			frame_end_q <= last;
		end
	end

endmodule
`default_nettype wire
